>>> sv/tlca_pkg.sv
package tlca_pkg;

   localparam int NODE_W         = 10;
   localparam int KIND_W         = 2;
   localparam int NODE_COUNT_DEF = 1024;
   localparam int PC_W           = 5;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] parent_node;
      logic [NODE_W-1:0] node_level;
      logic [NODE_W-1:0] other_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic [NODE_W-1:0] meet_u;
      logic [NODE_W-1:0] meet_v;
      logic              mark_cycle;
      logic              mark_unfinished;
      logic              mark_base;
      logic              error;
   } rsp_type;

   typedef enum logic [1:0] {UV_HOLD, UV_LOAD, UV_UP_U, UV_UP_V} uv_op_type;
   typedef enum logic [1:0] {MS_U, MS_V, MS_CLR} mark_sel_type;
   typedef enum logic [2:0] {RSP_NONE, RSP_ZERO, RSP_MARKS, RSP_MEET, RSP_ERROR} rsp_op_type;
   typedef enum logic [3:0] {
      C_NEXT, C_ALWAYS, C_NSTART, C_KIND, C_CLR_MORE,
      C_GAP_BIG, C_NOT_ULV, C_NOT_VLU, C_EXIT, C_PAR_EQ
   } cond_type;

   typedef struct packed {
      logic              cap_req;
      logic              q_en;
      uv_op_type         uv_op;
      logic              steps_clr;
      logic              steps_inc;
      logic              clr_rst;
      logic              clr_inc;
      logic              tree_we;
      mark_sel_type      mark_sel;
      logic              mk_cycle;
      logic              mk_unf;
      logic              mk_base;
      logic              mk_value;
      rsp_op_type        rsp_op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } ctrl_type;

   localparam logic [PC_W-1:0] L_IDLE     = 5'd0;
   localparam logic [PC_W-1:0] L_RED1     = 5'd1;
   localparam logic [PC_W-1:0] L_RED2     = 5'd2;
   localparam logic [PC_W-1:0] L_DISP     = 5'd3;
   localparam logic [PC_W-1:0] L_DO_LOAD  = L_DISP + PC_W'(KIND_LOAD);
   localparam logic [PC_W-1:0] L_DO_QUERY = L_DISP + PC_W'(KIND_QUERY);
   localparam logic [PC_W-1:0] L_DO_READ  = L_DISP + PC_W'(KIND_READ);
   localparam logic [PC_W-1:0] L_DO_CLEAR = L_DISP + PC_W'(KIND_CLEAR);
   localparam logic [PC_W-1:0] L_CLR      = 5'd7;
   localparam logic [PC_W-1:0] L_CLR_END  = 5'd8;
   localparam logic [PC_W-1:0] L_RST      = 5'd9;
   localparam logic [PC_W-1:0] L_RST_END  = 5'd10;
   localparam logic [PC_W-1:0] L_Q0       = 5'd11;
   localparam logic [PC_W-1:0] L_Q1       = 5'd12;
   localparam logic [PC_W-1:0] L_Q1_UP    = 5'd13;
   localparam logic [PC_W-1:0] L_Q2       = 5'd14;
   localparam logic [PC_W-1:0] L_Q2_UP    = 5'd15;
   localparam logic [PC_W-1:0] L_LOOP     = 5'd16;
   localparam logic [PC_W-1:0] L_CLIMB_V  = 5'd17;
   localparam logic [PC_W-1:0] L_CLIMB_U  = 5'd18;
   localparam logic [PC_W-1:0] L_EXIT     = 5'd19;
   localparam logic [PC_W-1:0] L_QERR     = 5'd20;
   localparam logic [PC_W-1:0] L_MEET_U   = 5'd21;
   localparam logic [PC_W-1:0] L_MEET_V   = 5'd22;

   // Control store: one word per program step.
   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w.cap_req   = 1'b0;
      w.q_en      = 1'b0;
      w.uv_op     = UV_HOLD;
      w.steps_clr = 1'b0;
      w.steps_inc = 1'b0;
      w.clr_rst   = 1'b0;
      w.clr_inc   = 1'b0;
      w.tree_we   = 1'b0;
      w.mark_sel  = MS_U;
      w.mk_cycle  = 1'b0;
      w.mk_unf    = 1'b0;
      w.mk_base   = 1'b0;
      w.mk_value  = 1'b1;
      w.rsp_op    = RSP_NONE;
      w.cond      = C_NEXT;
      w.target    = L_IDLE;
      unique case (pc) inside
         L_IDLE: begin
            w.cap_req = 1'b1;
            w.cond    = C_NSTART;
            w.target  = L_IDLE;
         end
         L_RED1: begin
            w.q_en = 1'b1;
         end
         L_RED2: begin
            w.uv_op     = UV_LOAD;
            w.steps_clr = 1'b1;
            w.cond      = C_KIND;
            w.target    = L_DISP;
         end
         L_DO_LOAD: begin
            w.tree_we = 1'b1;
            w.rsp_op  = RSP_ZERO;
            w.cond    = C_ALWAYS;
            w.target  = L_IDLE;
         end
         L_DO_QUERY: begin
            w.cond   = C_ALWAYS;
            w.target = L_Q0;
         end
         L_DO_READ: begin
            w.rsp_op = RSP_MARKS;
            w.cond   = C_ALWAYS;
            w.target = L_IDLE;
         end
         L_DO_CLEAR: begin
            w.clr_rst = 1'b1;
            w.cond    = C_ALWAYS;
            w.target  = L_CLR;
         end
         L_CLR, L_RST: begin
            w.mark_sel = MS_CLR;
            w.mk_cycle = 1'b1;
            w.mk_unf   = 1'b1;
            w.mk_base  = 1'b1;
            w.mk_value = 1'b0;
            w.clr_inc  = 1'b1;
            w.cond     = C_CLR_MORE;
            w.target   = pc;
         end
         L_CLR_END: begin
            w.rsp_op = RSP_ZERO;
            w.cond   = C_ALWAYS;
            w.target = L_IDLE;
         end
         L_RST_END: begin
            w.cond   = C_ALWAYS;
            w.target = L_IDLE;
         end
         L_Q0: begin
            w.cond   = C_GAP_BIG;
            w.target = L_QERR;
         end
         L_Q1: begin
            w.cond   = C_NOT_ULV;
            w.target = L_Q2;
         end
         L_Q1_UP, L_CLIMB_V: begin
            w.mark_sel = MS_V;
            w.mk_cycle = 1'b1;
            w.mk_unf   = 1'b1;
            w.uv_op    = UV_UP_V;
         end
         L_Q2: begin
            w.cond   = C_NOT_VLU;
            w.target = L_LOOP;
         end
         L_Q2_UP: begin
            w.mark_sel = MS_U;
            w.mk_cycle = 1'b1;
            w.mk_unf   = 1'b1;
            w.uv_op    = UV_UP_U;
         end
         L_LOOP: begin
            w.cond   = C_EXIT;
            w.target = L_EXIT;
         end
         L_CLIMB_U: begin
            w.mark_sel  = MS_U;
            w.mk_cycle  = 1'b1;
            w.mk_unf    = 1'b1;
            w.uv_op     = UV_UP_U;
            w.steps_inc = 1'b1;
            w.cond      = C_ALWAYS;
            w.target    = L_LOOP;
         end
         L_EXIT: begin
            w.cond   = C_PAR_EQ;
            w.target = L_MEET_U;
         end
         L_QERR: begin
            w.rsp_op = RSP_ERROR;
            w.cond   = C_ALWAYS;
            w.target = L_IDLE;
         end
         L_MEET_U: begin
            w.mark_sel = MS_U;
            w.mk_cycle = 1'b1;
            w.mk_base  = 1'b1;
         end
         L_MEET_V: begin
            w.mark_sel = MS_V;
            w.mk_cycle = 1'b1;
            w.mk_base  = 1'b1;
            w.rsp_op   = RSP_MEET;
            w.cond     = C_ALWAYS;
            w.target   = L_IDLE;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = L_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> sv/tlca_ram.sv
module tlca_ram import tlca_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = NODE_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tree_lca_walk_marker_top.sv
// Every item kind ends in a result strobe: a load, a mark read, a query that climbs in lockstep
// after evening out the levels (or reports an error when the level gap is too large), and a clear
// of all marks, which sweeps every mark entry and then returns an all-zero result.
// One item at a time: busy stays high until the result is out, set by the program sequencer
// and the one-read-per-side tree memories. The receiver cannot stall; the strobe lasts one cycle.
// Synchronous reset; afterwards a clearing pass over every mark entry holds busy high.
module tree_lca_walk_marker_top import tlca_pkg::*; #(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // Address width of every store, and the width of the climb counter, which must hold
   // NODE_COUNT itself.
   localparam int AW = $clog2(NODE_COUNT);
   localparam int SW = $clog2(NODE_COUNT + 1);

   // Node numbers arrive as 10-bit fields and are reduced modulo NODE_COUNT. The quotient
   // comes from a multiply by a rounded-up reciprocal, which is exact for every 10-bit value
   // when the shift is twice the field width. A store of at least 1024 entries needs no
   // reduction, so the reciprocal is zero and the value passes unchanged.
   localparam int FIELD_SPAN  = 2 ** NODE_W;
   localparam int RECIP_SHIFT = 2 * NODE_W;
   localparam int RECIP       = (NODE_COUNT < FIELD_SPAN) ?
                                ((2 ** RECIP_SHIFT) + NODE_COUNT - 1) / NODE_COUNT : 0;

   // A tree entry holds the raw parent (returned as the ancestor), the level, and the parent
   // already reduced to an address.
   localparam int TW = 2 * NODE_W + AW;
   localparam int NLANE = 3;

   ctrl_type cw;

   logic [PC_W-1:0] pc_ff, pc_in, jump_tgt;
   logic            take;

   req_type x_ff, x_in;

   logic [NODE_W-1:0] lane_x [NLANE];
   logic [NODE_W-1:0] q_ff [NLANE];
   logic [NODE_W-1:0] q_in [NLANE];
   logic [31:0]       prod [NLANE];
   logic [31:0]       rem  [NLANE];
   logic [AW-1:0]     red  [NLANE];

   logic [AW-1:0] u_ff, u_in, v_ff, v_in, p_ff, p_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic [TW-1:0]     tree_wdata, tree_a, tree_b;
   logic [NODE_W-1:0] raw_a, lvl_a, lvl_b;
   logic [AW-1:0]     rpar_a, rpar_b;
   logic [NODE_W-1:0] gap;
   logic              gap_big, over;

   logic [AW-1:0] mk_addr;
   logic          mk_cycle_q, mk_unf_q, mk_base_q;

   logic [31:0] u_wide, v_wide;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------------------------------
   // Sequencer: the control word of the current step drives the datapath below. A taken
   // condition loads the step's target (offset by the item kind for the dispatch step),
   // otherwise the step counter advances.
   // ---------------------------------------------------------------------------------------
   assign cw = ucode(pc_ff);

   always_comb begin
      unique case (cw.cond)
         C_NEXT:     take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_NSTART:   take = !start;
         C_KIND:     take = 1'b1;
         C_CLR_MORE: take = (clr_ff != AW'(NODE_COUNT - 1));
         C_GAP_BIG:  take = gap_big;
         C_NOT_ULV:  take = !(lvl_a < lvl_b);
         C_NOT_VLU:  take = !(lvl_b < lvl_a);
         C_EXIT:     take = (rpar_a == rpar_b) || over;
         C_PAR_EQ:   take = (rpar_a == rpar_b);
         default:    take = 1'b1;
      endcase
      jump_tgt = cw.target + ((cw.cond == C_KIND) ? PC_W'(x_ff.kind) : '0);
      pc_in    = take ? jump_tgt : pc_ff + 1'b1;
   end

   // Items are taken only at the idle step.
   assign x_in = (cw.cap_req && start) ? req_data : x_ff;

   // ---------------------------------------------------------------------------------------
   // Address reduction: three lanes (node, other node, parent). The quotient is registered,
   // and the remainder follows in the next step, when it is loaded into the walk registers.
   // ---------------------------------------------------------------------------------------
   assign lane_x[0] = x_ff.node;
   assign lane_x[1] = x_ff.other_node;
   assign lane_x[2] = x_ff.parent_node;

   always_comb begin
      for (int i = 0; i < NLANE; i++) begin
         prod[i] = 32'(lane_x[i]) * 32'(RECIP);
         q_in[i] = cw.q_en ? prod[i][RECIP_SHIFT +: NODE_W] : q_ff[i];
         rem[i]  = 32'(lane_x[i]) - 32'(q_ff[i]) * 32'(NODE_COUNT);
         red[i]  = rem[i][AW-1:0];
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tree stores. Each side of the climb has its own copy, both written on a load. The read
   // address is the next value of the walk register, so the registered read data always
   // belongs to the node now held in u or v.
   // ---------------------------------------------------------------------------------------
   assign tree_wdata = {x_ff.parent_node, x_ff.node_level, p_ff};

   tlca_ram #(.WIDTH(TW), .DEPTH(NODE_COUNT)) u_tree_u (
      .clock   (clock),
      .wr_en   (cw.tree_we),
      .wr_addr (u_ff),
      .wr_data (tree_wdata),
      .rd_addr (u_in),
      .rd_data (tree_a)
   );

   tlca_ram #(.WIDTH(TW), .DEPTH(NODE_COUNT)) u_tree_v (
      .clock   (clock),
      .wr_en   (cw.tree_we),
      .wr_addr (u_ff),
      .wr_data (tree_wdata),
      .rd_addr (v_in),
      .rd_data (tree_b)
   );

   assign raw_a  = tree_a[TW-1 -: NODE_W];
   assign lvl_a  = tree_a[AW +: NODE_W];
   assign rpar_a = tree_a[AW-1:0];
   assign lvl_b  = tree_b[AW +: NODE_W];
   assign rpar_b = tree_b[AW-1:0];

   assign gap     = (lvl_a > lvl_b) ? lvl_a - lvl_b : lvl_b - lvl_a;
   assign gap_big = (gap > NODE_W'(1));
   assign over    = (steps_ff == SW'(NODE_COUNT));

   // Walk registers.
   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      p_in = p_ff;
      unique case (cw.uv_op)
         UV_HOLD: ;
         UV_LOAD: begin
            u_in = red[0];
            v_in = red[1];
            p_in = red[2];
         end
         UV_UP_U: u_in = rpar_a;
         UV_UP_V: v_in = rpar_b;
         default: ;
      endcase
   end

   always_comb begin
      steps_in = steps_ff;
      if (cw.steps_clr) begin
         steps_in = '0;
      end else if (cw.steps_inc) begin
         steps_in = steps_ff + 1'b1;
      end
      clr_in = clr_ff;
      if (cw.clr_rst) begin
         clr_in = '0;
      end else if (cw.clr_inc) begin
         clr_in = clr_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Mark stores: one bit wide each, so a climb step sets cycle and unfinished without a
   // read-modify-write. The clearing pass writes zero at the sweep address.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      unique case (cw.mark_sel)
         MS_U:    mk_addr = u_ff;
         MS_V:    mk_addr = v_ff;
         MS_CLR:  mk_addr = clr_ff;
         default: mk_addr = u_ff;
      endcase
   end

   tlca_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_mark_cycle (
      .clock   (clock),
      .wr_en   (cw.mk_cycle),
      .wr_addr (mk_addr),
      .wr_data (cw.mk_value),
      .rd_addr (u_in),
      .rd_data (mk_cycle_q)
   );

   tlca_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_mark_unf (
      .clock   (clock),
      .wr_en   (cw.mk_unf),
      .wr_addr (mk_addr),
      .wr_data (cw.mk_value),
      .rd_addr (u_in),
      .rd_data (mk_unf_q)
   );

   tlca_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_mark_base (
      .clock   (clock),
      .wr_en   (cw.mk_base),
      .wr_addr (mk_addr),
      .wr_data (cw.mk_value),
      .rd_addr (u_in),
      .rd_data (mk_base_q)
   );

   // ---------------------------------------------------------------------------------------
   // Result register. Fields that do not apply to the item's kind are zero.
   // ---------------------------------------------------------------------------------------
   assign u_wide = 32'(u_ff);
   assign v_wide = 32'(v_ff);

   always_comb begin
      rsp_valid_in = (cw.rsp_op != RSP_NONE);
      rsp_data_in  = rsp_data_ff;
      unique case (cw.rsp_op)
         RSP_NONE: ;
         RSP_ZERO: rsp_data_in = '0;
         RSP_MARKS: begin
            rsp_data_in                 = '0;
            rsp_data_in.mark_cycle      = mk_cycle_q;
            rsp_data_in.mark_unfinished = mk_unf_q;
            rsp_data_in.mark_base       = mk_base_q;
         end
         RSP_MEET: begin
            rsp_data_in          = '0;
            rsp_data_in.ancestor = raw_a;
            rsp_data_in.meet_u   = u_wide[NODE_W-1:0];
            rsp_data_in.meet_v   = v_wide[NODE_W-1:0];
         end
         RSP_ERROR: begin
            rsp_data_in       = '0;
            rsp_data_in.error = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= L_RST;
         clr_ff       <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         clr_ff       <= clr_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      q_ff        <= q_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (pc_ff != L_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------------

   // The result leaves together with the return to the idle step.
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pc_ff == L_IDLE))
      else $error("result strobe while the sequencer is not idle");

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // The climb never runs past its bound.
   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= SW'(NODE_COUNT))
      else $error("climb counter above the node count");

   // A failed query reports no meeting nodes.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.error) |->
         (rsp_data_ff.ancestor == '0 && rsp_data_ff.meet_u == '0 && rsp_data_ff.meet_v == '0))
      else $error("error result carries meeting data");

endmodule

>>> sim/tb_tree_lca_walk_marker_top.sv
`timescale 1ns / 1ps

module tb_tree_lca_walk_marker_top;
   import tlca_pkg::*;

   // The watchdog ends the run after this many cycles in which no item is taken
   // and no result appears. The slowest legal item is a query that runs into
   // the walk limit. A clear sweeps every mark entry, and so does the clearing
   // pass after reset. The limit is several times the worst of these.
   localparam int STALL_LIMIT   = 20000;
   localparam int RANDOM_ITEMS  = 1125;
   localparam int NODE_MAX      = NODE_COUNT_DEF - 1;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   tree_lca_walk_marker_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Our own copy of the tree and of the three mark planes. It is updated at
   // the edge that takes each item, so it always matches what the block holds
   // once that item has been worked off.
   logic [NODE_W-1:0]         parent_mem [NODE_COUNT_DEF];
   logic [NODE_W-1:0]         level_mem  [NODE_COUNT_DEF];
   bit   [NODE_COUNT_DEF-1:0] cycle_bits;
   bit   [NODE_COUNT_DEF-1:0] unfinished_bits;
   bit   [NODE_COUNT_DEF-1:0] base_bits;

   // Answers the block still owes us, oldest first.
   rsp_type pending_answers[$];

   // Bookkeeping that keeps queries legal. Every loaded node has a loaded
   // parent, so any climb only ever reads entries that were written. The load
   // rank keeps the parent links free of loops: a node only ever points at
   // itself or at a node that was loaded before it.
   int          node_rank [NODE_COUNT_DEF];
   int unsigned loaded_nodes[$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   bit          no_gaps        = 1'b0;

   function automatic req_type pack_req(input logic [KIND_W-1:0] kind,
                                        input int unsigned node, parent_node,
                                        input int unsigned node_level, other_node);
      req_type r;
      r.kind        = kind;
      r.node        = NODE_W'(node);
      r.parent_node = NODE_W'(parent_node);
      r.node_level  = NODE_W'(node_level);
      r.other_node  = NODE_W'(other_node);
      return r;
   endfunction

   // A node passed on the way up lies on the cycle and is left unfinished.
   function automatic void mark_passed(input logic [NODE_W-1:0] n);
      cycle_bits[n]      = 1'b1;
      unfinished_bits[n] = 1'b1;
   endfunction

   // Works out the answer to one item and applies its side effects to our copy
   // of the tree and the marks. Fields that do not belong to the kind stay 0.
   function automatic rsp_type predict_answer(input req_type r);
      rsp_type           ans;
      logic [NODE_W-1:0] u;
      logic [NODE_W-1:0] v;
      int                lu;
      int                lv;
      int                steps;
      ans = '0;
      case (r.kind)
         KIND_LOAD: begin
            parent_mem[r.node] = r.parent_node;
            level_mem[r.node]  = r.node_level;
         end
         KIND_QUERY: begin
            u  = r.node;
            v  = r.other_node;
            lu = level_mem[u];
            lv = level_mem[v];
            if (lu - lv > 1 || lv - lu > 1) begin
               // Too far apart in depth: nothing is marked.
               ans.error = 1'b1;
            end else begin
               // Even out a gap of one. The second test sees the new v, so u can
               // still move here after v has moved.
               if (level_mem[u] < level_mem[v]) begin
                  mark_passed(v);
                  v = parent_mem[v];
               end
               if (level_mem[v] < level_mem[u]) begin
                  mark_passed(u);
                  u = parent_mem[u];
               end
               steps = 0;
               while (parent_mem[u] != parent_mem[v] && steps < NODE_COUNT_DEF) begin
                  mark_passed(v);
                  v = parent_mem[v];
                  mark_passed(u);
                  u = parent_mem[u];
                  steps++;
               end
               if (parent_mem[u] != parent_mem[v]) begin
                  // The walk gave up; the marks it left behind stay.
                  ans.error = 1'b1;
               end else begin
                  cycle_bits[u] = 1'b1;
                  cycle_bits[v] = 1'b1;
                  base_bits[u]  = 1'b1;
                  base_bits[v]  = 1'b1;
                  ans.ancestor  = parent_mem[u];
                  ans.meet_u    = u;
                  ans.meet_v    = v;
               end
            end
         end
         KIND_READ: begin
            ans.mark_cycle      = cycle_bits[r.node];
            ans.mark_unfinished = unfinished_bits[r.node];
            ans.mark_base       = base_bits[r.node];
         end
         default: begin
            cycle_bits      = '0;
            unfinished_bits = '0;
            base_bits       = '0;
         end
      endcase
      return ans;
   endfunction

   // Hands one item to the block. Every call begins in the time step of a
   // rising edge, either the one that took the previous item or a later one.
   // With no gap, start simply stays high and the new item waits behind busy.
   task automatic send_item(input req_type r);
      int unsigned gap;
      rsp_type     ans;
      if ($urandom_range(0, 19) == 0)
         no_gaps = !no_gaps;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      // The item is taken at the first edge that sees start high and busy low.
      do @(posedge clock); while (busy);
      ans             = predict_answer(r);
      pending_answers = {pending_answers, ans};
   endtask

   // Loads one node and keeps the list of legal query endpoints up to date.
   task automatic load_node(input int unsigned n, p, lvl);
      if (node_rank[n] < 0) begin
         node_rank[n] = loaded_nodes.size();
         loaded_nodes = {loaded_nodes, n};
      end
      send_item(pack_req(KIND_LOAD, n, p, lvl, $urandom_range(0, NODE_MAX)));
   endtask

   // Lets the block work off everything it owes, with start held low.
   task automatic drain_answers();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Every mark plane must come out of the clearing pass at zero.
   task automatic test_marks_after_reset();
      send_item(pack_req(KIND_READ, 0, 0, 0, 0));
      send_item(pack_req(KIND_READ, NODE_MAX, 0, 0, 0));
      send_item(pack_req(KIND_READ, 682, 0, 0, 0));
      drain_answers();
   endtask

   // A small tree under the highest node number, with some node numbers of
   // alternating bits. The queries cover a level climb on either side, a
   // meeting after one lockstep step, same endpoints and the root itself.
   task automatic test_tree_walks();
      load_node(NODE_MAX, NODE_MAX, 0);
      load_node(0, NODE_MAX, 1);
      load_node(682, NODE_MAX, 1);
      load_node(341, 0, 2);
      load_node(5, 682, 2);
      load_node(600, 5, 3);
      send_item(pack_req(KIND_QUERY, 341, 0, 0, 5));
      send_item(pack_req(KIND_QUERY, 600, 0, 0, 341));
      send_item(pack_req(KIND_QUERY, 341, 0, 0, 600));
      send_item(pack_req(KIND_QUERY, 0, 0, 0, 0));
      send_item(pack_req(KIND_QUERY, NODE_MAX, 0, 0, NODE_MAX));
      send_item(pack_req(KIND_READ, 5, 0, 0, 0));
      send_item(pack_req(KIND_READ, 341, 0, 0, 0));
      send_item(pack_req(KIND_READ, NODE_MAX, 0, 0, 0));
      drain_answers();
   endtask

   // The deepest levels, a gap of more than one, and two separate roots whose
   // climbs never meet, so the walk runs into its step limit.
   task automatic test_walk_errors();
      load_node(100, NODE_MAX, NODE_MAX);
      load_node(101, 100, NODE_MAX - 1);
      send_item(pack_req(KIND_QUERY, 100, 0, 0, 101));
      send_item(pack_req(KIND_QUERY, 600, 0, 0, NODE_MAX));
      load_node(900, 900, 0);
      send_item(pack_req(KIND_QUERY, 900, 0, 0, NODE_MAX));
      drain_answers();
   endtask

   // After a clear, a node that carried the cycle and unfinished marks reads back as clean.
   task automatic test_clear_marks();
      send_item(pack_req(KIND_CLEAR, NODE_MAX, NODE_MAX, NODE_MAX, NODE_MAX));
      send_item(pack_req(KIND_READ, 341, 0, 0, 0));
      drain_answers();
   endtask

   task automatic random_load();
      int unsigned n;
      int unsigned p;
      int unsigned lvl;
      int          r;
      if ($urandom_range(0, 9) < 7) begin
         do n = $urandom_range(0, NODE_MAX); while (node_rank[n] >= 0);
         if ($urandom_range(0, 99) < 3)
            p = n;
         else
            p = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
      end else begin
         // Moving an existing node stays loop free: its new parent was loaded
         // before it, and so was every parent above that one.
         n = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
         r = node_rank[n];
         if (r == 0 || $urandom_range(0, 9) == 0)
            p = n;
         else
            p = loaded_nodes[$urandom_range(0, r - 1)];
      end
      // Most levels are consistent with the tree; the rest are arbitrary and
      // stir up gap errors and lopsided climbs.
      if ($urandom_range(0, 99) < 15)
         lvl = $urandom_range(0, NODE_MAX);
      else if (p == n)
         lvl = 0;
      else
         lvl = (level_mem[p] + 1) % NODE_COUNT_DEF;
      load_node(n, p, lvl);
   endtask

   task automatic random_query();
      int unsigned u;
      int unsigned v;
      int unsigned pick;
      int          tries;
      u    = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
      v    = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         v = u;
      end else if (pick < 85) begin
         // Look for a partner within one level, which is what a real
         // non-tree edge of a breadth-first tree looks like.
         for (tries = 0; tries < 16; tries++) begin
            if (level_mem[u] <= level_mem[v] + 1 && level_mem[v] <= level_mem[u] + 1)
               break;
            v = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
         end
      end
      send_item(pack_req(KIND_QUERY, u, $urandom_range(0, NODE_MAX),
                         $urandom_range(0, NODE_MAX), v));
   endtask

   // Mixed traffic on a growing forest: loads, queries, mark reads and the
   // odd clear of all marks. Unused fields carry random bits throughout.
   task automatic test_random_traffic();
      int          i;
      int unsigned sel;
      int unsigned n;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            random_load();
         end else if (sel < 75) begin
            random_query();
         end else if (sel < 98) begin
            if ($urandom_range(0, 1) == 0)
               n = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
            else
               n = $urandom_range(0, NODE_MAX);
            send_item(pack_req(KIND_READ, n, $urandom_range(0, NODE_MAX),
                               $urandom_range(0, NODE_MAX), $urandom_range(0, NODE_MAX)));
         end else begin
            send_item(pack_req(KIND_CLEAR, $urandom_range(0, NODE_MAX),
                               $urandom_range(0, NODE_MAX), $urandom_range(0, NODE_MAX),
                               $urandom_range(0, NODE_MAX)));
         end
      end
      drain_answers();
   endtask

   task automatic check_field(input string name, input logic [NODE_W-1:0] want, got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Every strobe is one answer, and it must match the oldest one we predicted.
   always @(posedge clock) begin : answer_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            check_field("ancestor", want.ancestor, rsp_data.ancestor);
            check_field("meet_u", want.meet_u, rsp_data.meet_u);
            check_field("meet_v", want.meet_v, rsp_data.meet_v);
            check_field("mark_cycle", want.mark_cycle, rsp_data.mark_cycle);
            check_field("mark_unfinished", want.mark_unfinished, rsp_data.mark_unfinished);
            check_field("mark_base", want.mark_base, rsp_data.mark_base);
            check_field("error", want.error, rsp_data.error);
         end
      end
   end

   // Counts cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      for (i = 0; i < NODE_COUNT_DEF; i++)
         node_rank[i] = -1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // The block runs its own clearing pass now; the first item simply
      // waits behind busy.
      test_marks_after_reset();
      test_tree_walks();
      test_walk_errors();
      test_clear_marks();
      test_random_traffic();
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
